FILE: hw/rtl/stepcmd_pkg.sv
// Shared types, codes and constants for the stepper command controller.
// Depends on nothing; imported by stepper_command_controller.
package stepcmd_pkg;

    // Packet framing state: which byte of the five-byte packet comes next
    typedef enum logic [2:0] {
        FRAME_IDLE = 3'd0,
        FRAME_CMD  = 3'd1,
        FRAME_DHI  = 3'd2,
        FRAME_DLO  = 3'd3,
        FRAME_ESC  = 3'd4
    } frame_state_t;

    // Motion modes as reported on the result channel
    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_FWD    = 2'd1,
        MODE_REV    = 2'd2,
        MODE_SINGLE = 2'd3
    } motion_mode_t;

    // Stepper command codes; every other code is accepted and ignored
    localparam logic [7:0] CMD_STEP_FWD  = 8'd3;
    localparam logic [7:0] CMD_STEP_REV  = 8'd4;
    localparam logic [7:0] CMD_RUN_FWD   = 8'd5;
    localparam logic [7:0] CMD_RUN_REV   = 8'd6;
    localparam logic [7:0] CMD_STOP      = 8'd7;
    localparam logic [7:0] CMD_ZERO      = 8'd10;
    localparam logic [7:0] CMD_GOTO      = 8'd11;
    localparam logic [7:0] CMD_PRELOAD   = 8'd12;
    localparam logic [7:0] CMD_XY_START  = 8'd14;

    localparam logic [7:0]  START_BYTE   = 8'hFF;
    localparam logic [7:0]  ESCAPED_BYTE = 8'hFF;
    localparam logic [15:0] FULL_PERIOD  = 16'hFFFF;
    localparam logic [15:0] GOTO_PERIOD_RESET = 16'hFFFF - 16'hBD4C;

    // Encoder counts per half step: 0xFFFF/123*2*20/400 = 53
    localparam int unsigned STEPS_DIVISOR = 65535 / 123 * 2 * 20 / 400;
    // data / 53 == (data * 39569) >> 21 for every 16-bit data word
    localparam logic [15:0] DIV_RECIP = 16'd39569;
    localparam int unsigned DIV_SHIFT = 21;

    // Half-step coil patterns, A1,A2,B1,B2 in bits 0..3
    function automatic logic [3:0] half_step_coils(input logic [2:0] idx);
        logic [3:0] pat;
        case (idx)
            3'd0:    pat = 4'd1;
            3'd1:    pat = 4'd5;
            3'd2:    pat = 4'd4;
            3'd3:    pat = 4'd6;
            3'd4:    pat = 4'd2;
            3'd5:    pat = 4'd10;
            3'd6:    pat = 4'd8;
            3'd7:    pat = 4'd9;
            default: pat = 4'd1;
        endcase
        return pat;
    endfunction

    // Full-step coil patterns (A1, B1, A2, B2)
    function automatic logic [3:0] full_step_coils(input logic [1:0] idx);
        logic [3:0] pat;
        case (idx)
            2'd0:    pat = 4'd1;
            2'd1:    pat = 4'd4;
            2'd2:    pat = 4'd2;
            2'd3:    pat = 4'd8;
            default: pat = 4'd1;
        endcase
        return pat;
    endfunction

endpackage

FILE: hw/rtl/stepper_command_controller.sv
// Stepper command controller: packet decoder, motion state and coil sequencer.
// Depends on stepcmd_pkg for codes, constants and coil tables.
//
// Usage:
//   Input stream (s_axis_*): tuser 0 carries a received serial byte in tdata,
//   tuser 1 is a step timer tick (tdata ignored). Packets are five bytes:
//   start byte 255, command, data high, data low, escape flags.
//   Result stream (m_axis_*): one transaction per input transaction, giving
//   coil pattern, power flag, position, mode, step period and seek flag in
//   tdata; tlast is set when the input completed a packet.
//   Config port: goto_period_wr_en/goto_period_wr_data load the step period
//   used by the go-to-position command.
// Latency and throughput: the result is valid the cycle after the input
//   transaction; one input per cycle is taken as long as the result stream
//   keeps up. The state registers double as the result register, so the
//   path per cycle is one 16x16 reciprocal multiply and a position compare.
// Reset: position, target, framing and mode clear, step period is 65535,
//   go-to period is 17075, no result pending.
// Stall: while a result waits for m_axis_tready, s_axis_tready is low and all
//   but goto_period_reg holds; a result taken in the same cycle frees the slot.
module stepper_command_controller #(
    parameter int PHASE_COUNT = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] command (0 byte, 1 tick)
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] coil_pattern, [4] coils_powered, [20:5] position,
    // [22:21] step_mode, [38:23] step_period, [39] seeking
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast,   // packet_done
    // configuration
    input  logic        goto_period_wr_en,
    input  logic [15:0] goto_period_wr_data
);
    import stepcmd_pkg::*;

    localparam int PHASE_W = $clog2(PHASE_COUNT);
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PHASE_COUNT - 1);
    localparam logic [PHASE_W-1:0] PHASE_WRAP = PHASE_W'(65535 % PHASE_COUNT);

    // State registers
    frame_state_t       frame_reg, frame_next;
    logic [7:0]         cmd_reg, cmd_next;
    logic [7:0]         dhi_reg, dhi_next;
    logic [7:0]         dlo_reg, dlo_next;
    logic [15:0]        pos_reg, pos_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [15:0]        target_reg, target_next;
    motion_mode_t       mode_reg, mode_next;
    logic               seek_reg, seek_next;
    logic [15:0]        period_reg, period_next;
    logic [15:0]        goto_period_reg;
    logic               done_reg, done_next;
    logic               out_valid_reg, out_valid_next;

    logic        in_fire;
    logic        step_up, step_dn, step_zero;
    logic [15:0] data_word;
    logic [31:0] div_prod;
    logic [15:0] data_quot;
    logic [15:0] dir_target;
    logic [3:0]  coil_pattern;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;

    // Build the data word with escape substitution
    always_comb
    begin
        data_word[15:8] = s_axis_tdata[1] ? ESCAPED_BYTE : dhi_reg;
        data_word[7:0]  = s_axis_tdata[0] ? ESCAPED_BYTE : dlo_reg;
    end

    // Divide data by the steps divisor through a reciprocal multiply
    assign div_prod  = 32'(data_word) * 32'(DIV_RECIP);
    assign data_quot = 16'(div_prod >> DIV_SHIFT);

    // Decode bytes, execute commands and run ticks
    always_comb
    begin
        frame_next  = frame_reg;
        cmd_next    = cmd_reg;
        dhi_next    = dhi_reg;
        dlo_next    = dlo_reg;
        target_next = target_reg;
        mode_next   = mode_reg;
        seek_next   = seek_reg;
        period_next = period_reg;
        done_next   = done_reg;
        step_up     = 1'b0;
        step_dn     = 1'b0;
        step_zero   = 1'b0;
        dir_target  = (cmd_reg == CMD_GOTO) ? data_quot : target_reg;

        if (in_fire)
        begin
            done_next = 1'b0;
            if (s_axis_tuser)
            begin
                step_up = (mode_reg == MODE_FWD);
                step_dn = (mode_reg == MODE_REV);
            end
            else
            begin
                case (frame_reg)
                    FRAME_IDLE:
                    begin
                        if (s_axis_tdata == START_BYTE)
                        begin
                            frame_next = FRAME_CMD;
                        end
                    end
                    FRAME_CMD:
                    begin
                        cmd_next   = s_axis_tdata;
                        frame_next = FRAME_DHI;
                    end
                    FRAME_DHI:
                    begin
                        dhi_next   = s_axis_tdata;
                        frame_next = FRAME_DLO;
                    end
                    FRAME_DLO:
                    begin
                        dlo_next   = s_axis_tdata;
                        frame_next = FRAME_ESC;
                    end
                    default:
                    begin
                        frame_next = FRAME_IDLE;
                        done_next  = 1'b1;
                        case (cmd_reg)
                            CMD_STEP_FWD:
                            begin
                                mode_next = MODE_SINGLE;
                                step_up   = 1'b1;
                            end
                            CMD_STEP_REV:
                            begin
                                mode_next = MODE_SINGLE;
                                step_dn   = 1'b1;
                            end
                            CMD_RUN_FWD:
                            begin
                                mode_next   = MODE_FWD;
                                period_next = FULL_PERIOD - data_word;
                            end
                            CMD_RUN_REV:
                            begin
                                mode_next   = MODE_REV;
                                period_next = FULL_PERIOD - data_word;
                            end
                            CMD_STOP:
                            begin
                                mode_next = MODE_OFF;
                            end
                            CMD_ZERO:
                            begin
                                mode_next = MODE_SINGLE;
                                step_zero = 1'b1;
                            end
                            CMD_GOTO, CMD_XY_START:
                            begin
                                if (cmd_reg == CMD_GOTO)
                                begin
                                    target_next = data_quot;
                                    period_next = goto_period_reg;
                                end
                                else
                                begin
                                    period_next = FULL_PERIOD - data_word;
                                end
                                seek_next = 1'b1;
                                // head toward target; keep mode if already there
                                if (pos_reg < dir_target)
                                begin
                                    mode_next = MODE_FWD;
                                end
                                else if (pos_reg > dir_target)
                                begin
                                    mode_next = MODE_REV;
                                end
                            end
                            CMD_PRELOAD:
                            begin
                                mode_next   = MODE_OFF;
                                seek_next   = 1'b0;
                                target_next = data_quot;
                            end
                            default:
                            begin
                                mode_next = mode_reg;
                            end
                        endcase
                    end
                endcase
            end
        end

        // Zero or advance position and its phase, wrapping modulo 65536
        pos_next   = pos_reg;
        phase_next = phase_reg;
        if (step_zero)
        begin
            pos_next   = '0;
            phase_next = '0;
        end
        else if (step_up)
        begin
            pos_next   = pos_reg + 16'd1;
            phase_next = (pos_reg == 16'hFFFF || phase_reg == PHASE_LAST)
                         ? '0 : phase_reg + PHASE_W'(1);
        end
        else if (step_dn)
        begin
            pos_next = pos_reg - 16'd1;
            if (pos_reg == 16'd0)
            begin
                phase_next = PHASE_WRAP;
            end
            else
            begin
                phase_next = (phase_reg == '0) ? PHASE_LAST : phase_reg - PHASE_W'(1);
            end
        end

        // End a seek when a tick lands on the target
        if (in_fire && s_axis_tuser && seek_reg && pos_next == target_reg)
        begin
            seek_next = 1'b0;
            mode_next = MODE_OFF;
        end

        // Hold a result until the sink takes it
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg       <= FRAME_IDLE;
            cmd_reg         <= '0;
            dhi_reg         <= '0;
            dlo_reg         <= '0;
            pos_reg         <= '0;
            phase_reg       <= '0;
            target_reg      <= '0;
            mode_reg        <= MODE_OFF;
            seek_reg        <= 1'b0;
            period_reg      <= FULL_PERIOD;
            goto_period_reg <= GOTO_PERIOD_RESET;
            done_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            frame_reg     <= frame_next;
            cmd_reg       <= cmd_next;
            dhi_reg       <= dhi_next;
            dlo_reg       <= dlo_next;
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            target_reg    <= target_next;
            mode_reg      <= mode_next;
            seek_reg      <= seek_next;
            period_reg    <= period_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
            if (goto_period_wr_en)
            begin
                goto_period_reg <= goto_period_wr_data;
            end
        end
    end

    // Look up the coil pattern for the current phase
    assign coil_pattern = (PHASE_COUNT == 4) ? full_step_coils(phase_reg[1:0])
                                             : half_step_coils(3'(phase_reg));

    // Pack the result transaction
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {seek_reg, period_reg, 2'(mode_reg),
                            pos_reg, (mode_reg != MODE_OFF), coil_pattern};
    assign m_axis_tlast  = done_reg;

    // Phase counter tracks the position modulo the phase count
    assert property (@(posedge clk) disable iff (!rst_n)
        (32'(pos_reg) % PHASE_COUNT) == 32'(phase_reg))
        else $error("phase counter out of step with position");

    // A stalled result freezes the motion state
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(pos_reg) && $stable(mode_reg))
        else $error("state moved while result stalled");

    // A completed packet leaves the framer idle
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && done_reg |-> frame_reg == FRAME_IDLE)
        else $error("packet done with framer not idle");

    // Ending a seek always powers the coils down
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(seek_reg) |-> mode_reg == MODE_OFF)
        else $error("seek ended with motion still on");

endmodule
